// ----- sv/lrss_pkg.sv -----
`timescale 1ns / 1ps
// Package for the second-smallest removal buffer.
// Holds opcodes, status codes, controller states and the command and status structs.
// No dependencies.
package lrss_pkg;

  // Default buffer depth.
  localparam int DEPTH_DEF = 32;

  // Width of the stored values.
  localparam int VAL_W = 32;

  // Operation codes carried on the input tuser.
  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  // Result status codes carried on the output tuser.
  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_SINGLE = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_SHIFT,
    S_RD_ISSUE,
    S_RD_EMIT
  } state_t;

  // Element count update.
  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_CLR
  } cnt_op_t;

  // Scan and shift pointer update.
  typedef enum logic [1:0] {
    PTR_HOLD,
    PTR_ZERO,
    PTR_SECOND,
    PTR_INC
  } ptr_op_t;

  // What the output register is loaded with.
  typedef enum logic [1:0] {
    OUT_NONE,
    OUT_STATUS,
    OUT_ELEM
  } out_kind_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      in_load;
    cnt_op_t   cnt_op;
    ptr_op_t   ptr_op;
    logic      rd_en;
    logic      scan_en;
    logic      wr_append;
    logic      wr_shift;
    out_kind_t out_kind;
    status_t   out_status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    op_t  op;
    logic count_zero;
    logic count_one;
    logic full;
    logic ptr_at_end;
    logic rd_vld;
    logic rd_last;
    logic out_free;
  } sts_t;

endpackage

// ----- sv/list_remove_second_smallest_top.sv -----
`timescale 1ns / 1ps
// Ordered buffer that removes its second-smallest element.
// Append and clear load their result in the dispatch state; remove runs a dispatch step, a scan of
// every element and a shift of the elements after the second-smallest one; read alternates an
// issue state and an emit state for each element, and waits while the output register is full.
// One item is worked on at a time; the next item is accepted once the last result is loaded.
// Reset empties the buffer and the output register; stored values are undefined until written.
module list_remove_second_smallest_top
  import lrss_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] value
  input  logic [1:0]  s_tuser,   // [1:0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] data
  output logic [1:0]  m_tuser,   // [1:0] status
  output logic        m_tlast
);

  cmd_t                    cmd;
  sts_t                    sts;
  logic signed [VAL_W-1:0] out_data;
  status_t                 out_status;

  // Sequencer.
  lrss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Storage and compare logic.
  lrss_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_opcode  (s_tuser),
    .in_value   (s_tdata),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (out_data),
    .out_status (out_status),
    .out_last   (m_tlast)
  );

  assign m_tdata = out_data;
  assign m_tuser = out_status;

endmodule

// ----- sv/lrss_datapath.sv -----
`timescale 1ns / 1ps
// Datapath of the second-smallest removal buffer: element memory, count,
// scan pointer, running minima and the output register. Depends on lrss_pkg.
module lrss_datapath
  import lrss_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  cmd_t                    cmd,
  output sts_t                    sts,
  input  logic [1:0]              in_opcode,
  input  logic signed [VAL_W-1:0] in_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [VAL_W-1:0] out_data,
  output status_t                 out_status,
  output logic                    out_last
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic signed [VAL_W-1:0] mem [DEPTH];
  logic signed [VAL_W-1:0] rd_data;
  logic                    rd_vld;
  logic [AW-1:0]           idx_q;
  logic [CW-1:0]           count;
  logic [CW-1:0]           ptr;
  op_t                     op_q;
  logic signed [VAL_W-1:0] val_q;
  logic [AW-1:0]           lo_idx;
  logic signed [VAL_W-1:0] lo_val;
  logic [AW-1:0]           sec_idx;
  logic signed [VAL_W-1:0] sec_val;
  logic                    have2;
  logic                    out_free;

  assign out_free = !out_valid || out_ready;

  // Status back to the controller.
  always_comb begin
    sts.op         = op_q;
    sts.count_zero = (count == '0);
    sts.count_one  = (count == CW'(1));
    sts.full       = (count == CW'(DEPTH));
    sts.ptr_at_end = (ptr == count);
    sts.rd_vld     = rd_vld;
    sts.rd_last    = ((CW'(idx_q) + CW'(1)) == count);
    sts.out_free   = out_free;
  end

  // Captured input item.
  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      op_q  <= op_t'(in_opcode);
      val_q <= in_value;
    end
  end

  // Element count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (cmd.cnt_op)
        CNT_INC: count <= count + CW'(1);
        CNT_DEC: count <= count - CW'(1);
        CNT_CLR: count <= '0;
        default: count <= count;
      endcase
    end
  end

  // Scan and shift pointer.
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr <= '0;
    end else begin
      case (cmd.ptr_op)
        PTR_ZERO:   ptr <= '0;
        PTR_SECOND: ptr <= CW'(sec_idx) + CW'(1);
        PTR_INC:    ptr <= ptr + CW'(1);
        default:    ptr <= ptr;
      endcase
    end
  end

  // Element memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.wr_append) begin
      mem[count[AW-1:0]] <= val_q;
    end else if (cmd.wr_shift) begin
      mem[idx_q - AW'(1)] <= rd_data;
    end
    if (cmd.rd_en) begin
      rd_data <= mem[ptr[AW-1:0]];
      idx_q   <= ptr[AW-1:0];
    end
  end

  // Read data valid flag, set in the cycle after each read.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld <= 1'b0;
    end else begin
      rd_vld <= cmd.rd_en;
    end
  end

  // Running minimum and runner-up; among equal values the earlier one stays minimum.
  always_ff @(posedge clk) begin
    if (rst) begin
      have2 <= 1'b0;
    end else if (cmd.scan_en && rd_vld) begin
      if (idx_q == '0) begin
        lo_idx <= '0;
        lo_val <= rd_data;
        have2  <= 1'b0;
      end else if (rd_data < lo_val) begin
        sec_idx <= lo_idx;
        sec_val <= lo_val;
        lo_idx  <= idx_q;
        lo_val  <= rd_data;
        have2   <= 1'b1;
      end else if (!have2 || (rd_data < sec_val)) begin
        sec_idx <= idx_q;
        sec_val <= rd_data;
        have2   <= 1'b1;
      end
    end
  end

  // Output register: valid flag cleared when taken, set on a load.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_kind != OUT_NONE) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    case (cmd.out_kind)
      OUT_STATUS: begin
        out_data   <= '0;
        out_status <= cmd.out_status;
        out_last   <= 1'b1;
      end
      OUT_ELEM: begin
        out_data   <= rd_data;
        out_status <= ST_OK;
        out_last   <= sts.rd_last;
      end
      default: begin
        out_data   <= out_data;
        out_status <= out_status;
        out_last   <= out_last;
      end
    endcase
  end

  // The count never grows past the depth.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("element count exceeds depth");

  // A shift write always uses freshly read data.
  a_shift_data: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_shift |-> rd_vld)
    else $error("shift write without read data");

  // A result is never loaded over one that is still waiting.
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.out_kind != OUT_NONE) |-> out_free)
    else $error("output register overwritten");

  // Only element results of a read come without the last mark.
  a_not_last_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_last) |-> (out_status == ST_OK))
    else $error("non-final result with error status");

endmodule

// ----- sv/lrss_ctrl.sv -----
`timescale 1ns / 1ps
// Controller of the second-smallest removal buffer: sequences append, remove,
// read and clear over the datapath. Depends on lrss_pkg.
module lrss_ctrl
  import lrss_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands.
  always_comb begin
    state_next     = state;
    in_ready       = 1'b0;
    cmd.in_load    = 1'b0;
    cmd.cnt_op     = CNT_HOLD;
    cmd.ptr_op     = PTR_HOLD;
    cmd.rd_en      = 1'b0;
    cmd.scan_en    = 1'b0;
    cmd.wr_append  = 1'b0;
    cmd.wr_shift   = 1'b0;
    cmd.out_kind   = OUT_NONE;
    cmd.out_status = ST_OK;

    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.in_load = 1'b1;
          state_next  = S_DISPATCH;
        end
      end

      S_DISPATCH: begin
        if (sts.out_free) begin
          unique case (sts.op)
            OP_APPEND: begin
              cmd.out_kind = OUT_STATUS;
              state_next   = S_IDLE;
              if (sts.full) begin
                cmd.out_status = ST_FULL;
              end else begin
                cmd.wr_append = 1'b1;
                cmd.cnt_op    = CNT_INC;
              end
            end
            OP_CLEAR: begin
              cmd.cnt_op   = CNT_CLR;
              cmd.out_kind = OUT_STATUS;
              state_next   = S_IDLE;
            end
            OP_REMOVE: begin
              if (sts.count_zero) begin
                cmd.out_kind   = OUT_STATUS;
                cmd.out_status = ST_EMPTY;
                state_next     = S_IDLE;
              end else if (sts.count_one) begin
                cmd.out_kind   = OUT_STATUS;
                cmd.out_status = ST_SINGLE;
                state_next     = S_IDLE;
              end else begin
                cmd.ptr_op = PTR_ZERO;
                state_next = S_SCAN;
              end
            end
            OP_READ: begin
              if (sts.count_zero) begin
                cmd.out_kind   = OUT_STATUS;
                cmd.out_status = ST_EMPTY;
                state_next     = S_IDLE;
              end else begin
                cmd.ptr_op = PTR_ZERO;
                state_next = S_RD_ISSUE;
              end
            end
            default: state_next = S_IDLE;
          endcase
        end
      end

      // Stream every element through the minimum tracker, one per cycle.
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (!sts.ptr_at_end) begin
          cmd.rd_en  = 1'b1;
          cmd.ptr_op = PTR_INC;
        end else if (!sts.rd_vld) begin
          cmd.ptr_op = PTR_SECOND;
          state_next = S_SHIFT;
        end
      end

      // Move each element after the removed one down by one place.
      S_SHIFT: begin
        cmd.wr_shift = sts.rd_vld;
        if (!sts.ptr_at_end) begin
          cmd.rd_en  = 1'b1;
          cmd.ptr_op = PTR_INC;
        end else if (!sts.rd_vld && sts.out_free) begin
          cmd.cnt_op   = CNT_DEC;
          cmd.out_kind = OUT_STATUS;
          state_next   = S_IDLE;
        end
      end

      S_RD_ISSUE: begin
        cmd.rd_en  = 1'b1;
        cmd.ptr_op = PTR_INC;
        state_next = S_RD_EMIT;
      end

      S_RD_EMIT: begin
        if (sts.out_free) begin
          cmd.out_kind = OUT_ELEM;
          state_next   = sts.rd_last ? S_IDLE : S_RD_ISSUE;
        end
      end

      default: state_next = S_IDLE;
    endcase
  end

endmodule

// ----- bench/list_remove_second_smallest_checker.sv -----
`timescale 1ns / 1ps
// Checker for the second-smallest removal buffer: watches both streams, predicts results.
// Depends on lrss_pkg for the opcode and status enums.
module list_remove_second_smallest_checker
  import lrss_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic [1:0]  s_tuser,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,
  input  logic [1:0]  m_tuser,
  input  logic        m_tlast,
  output int          errors,
  output int          outstanding
);

  typedef struct {
    logic [31:0] data;
    status_t     status;
    logic        last;
  } result_t;

  // Shadow copy of the buffer contents, oldest element first.
  logic signed [31:0] stored_values[$];
  // Results still owed by the block, oldest first.
  result_t            awaited_results[$];
  int                 fail_count = 0;

  assign errors      = fail_count;
  assign outstanding = awaited_results.size();

  function automatic void owe_result(logic [31:0] d, status_t st, logic lst);
    result_t r;
    r.data   = d;
    r.status = st;
    r.last   = lst;
    awaited_results.push_back(r);
  endfunction

  // Updates the shadow buffer for one command and queues the results it causes.
  function automatic void predict_command(op_t op, logic [31:0] v);
    int lo;
    int second;
    int n;
    n = stored_values.size();
    case (op)
      OP_APPEND: begin
        if (n >= DEPTH) begin
          owe_result('0, ST_FULL, 1'b1);
        end else begin
          stored_values.push_back(v);
          owe_result('0, ST_OK, 1'b1);
        end
      end
      OP_REMOVE: begin
        if (n == 0) begin
          owe_result('0, ST_EMPTY, 1'b1);
        end else if (n == 1) begin
          owe_result('0, ST_SINGLE, 1'b1);
        end else begin
          // The first two seed the ranking; on a tie the earlier one is the minimum.
          lo     = 0;
          second = 1;
          if (stored_values[1] < stored_values[0]) begin
            lo     = 1;
            second = 0;
          end
          for (int j = 2; j < n; j++) begin
            if (stored_values[j] < stored_values[lo]) begin
              second = lo;
              lo     = j;
            end else if (stored_values[j] < stored_values[second]) begin
              second = j;
            end
          end
          stored_values.delete(second);
          owe_result('0, ST_OK, 1'b1);
        end
      end
      OP_READ: begin
        if (n == 0) begin
          owe_result('0, ST_EMPTY, 1'b1);
        end else begin
          for (int j = 0; j < n; j++) begin
            owe_result(stored_values[j], ST_OK, j == n - 1);
          end
        end
      end
      OP_CLEAR: begin
        stored_values.delete();
        owe_result('0, ST_OK, 1'b1);
      end
    endcase
  endfunction

  // Compare each delivered result with the oldest prediction, then absorb new commands.
  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      stored_values.delete();
      awaited_results.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result, data %h status %0d last %b",
                   $time, m_tdata, m_tuser, m_tlast);
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          if (m_tdata !== want.data) begin
            $display("%0t: data mismatch, expected %h, got %h", $time, want.data, m_tdata);
            fail_count++;
          end
          if (m_tuser !== want.status) begin
            $display("%0t: status mismatch, expected %0d, got %0d",
                     $time, want.status, m_tuser);
            fail_count++;
          end
          if (m_tlast !== want.last) begin
            $display("%0t: last mismatch, expected %b, got %b", $time, want.last, m_tlast);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        predict_command(op_t'(s_tuser), s_tdata);
      end
    end
  end

endmodule

// ----- bench/list_remove_second_smallest_top_tb.sv -----
`timescale 1ns / 1ps
// Top of the testbench: drives commands into the second-smallest removal buffer.
// Depends on lrss_pkg, list_remove_second_smallest_top and list_remove_second_smallest_checker.
module list_remove_second_smallest_top_tb;
  import lrss_pkg::*;

  localparam int DEPTH        = DEPTH_DEF;
  localparam int ITEM_TARGET  = 480;
  localparam int DRAIN_CYCLES = 2 * DEPTH + 8;
  localparam int HOLD_CYCLES  = 400;
  localparam logic [31:0] CORNERS [4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic [1:0]  m_tuser;
  logic        m_tlast;

  int errors;
  int outstanding;
  int items_sent    = 0;
  int results_taken = 0;
  int reader_wait;
  bit reader_held   = 1'b0;

  list_remove_second_smallest_top #(.DEPTH(DEPTH)) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  list_remove_second_smallest_checker #(.DEPTH(DEPTH)) u_checker (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .s_tuser     (s_tuser),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .m_tuser     (m_tuser),
    .m_tlast     (m_tlast),
    .errors      (errors),
    .outstanding (outstanding)
  );

  // 100 MHz clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Idle cycles before an item; every fourth group of 32 items runs back to back.
  function automatic int draw_gap(int idx);
    if ((idx / 32) % 4 == 3) return 0;
    return $urandom_range(0, 12);
  endfunction

  // Values lean toward small numbers so that ties are common, with corners mixed in.
  function automatic logic [31:0] rand_value();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return 32'($urandom_range(0, 6) - 3);
      2: return CORNERS[$urandom_range(0, 3)];
      default: return $urandom_range(0, 15);
    endcase
  endfunction

  // Command mix for ordinary sessions.
  function automatic op_t rand_op();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return OP_APPEND;
    if (r < 75) return OP_REMOVE;
    if (r < 92) return OP_READ;
    return OP_CLEAR;
  endfunction

  // Offers one item and returns at the edge where it is accepted; valid stays high.
  task automatic send_item(input op_t op, input logic [31:0] v);
    int gap;
    gap = draw_gap(items_sent);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= v;
    do begin
      @(posedge clk);
    end while (!s_tready);
    items_sent++;
  endtask

  // Fills the buffer, offers appends past its depth, reads it back and trims it a little.
  task automatic fill_buffer();
    send_item(OP_CLEAR, $urandom());
    repeat (DEPTH + 2) send_item(OP_APPEND, rand_value());
    send_item(OP_READ, $urandom());
    repeat (3) send_item(OP_REMOVE, $urandom());
    send_item(OP_READ, $urandom());
  endtask

  // Command stream.
  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = OP_APPEND;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Empty buffer, single element, extremes and ties.
    send_item(OP_READ, $urandom());
    send_item(OP_REMOVE, $urandom());
    send_item(OP_CLEAR, $urandom());
    send_item(OP_APPEND, 32'h8000_0000);
    send_item(OP_REMOVE, $urandom());
    send_item(OP_READ, $urandom());
    send_item(OP_APPEND, 32'h7FFF_FFFF);
    send_item(OP_APPEND, 32'h0000_0000);
    send_item(OP_APPEND, 32'hFFFF_FFFF);
    send_item(OP_APPEND, 32'd5);
    send_item(OP_APPEND, 32'd5);
    send_item(OP_READ, $urandom());
    send_item(OP_REMOVE, $urandom());
    send_item(OP_REMOVE, $urandom());
    send_item(OP_READ, $urandom());
    send_item(OP_CLEAR, $urandom());
    // Equal first pair: the later copy ranks second.
    send_item(OP_APPEND, 32'd3);
    send_item(OP_APPEND, 32'd3);
    send_item(OP_REMOVE, $urandom());
    send_item(OP_READ, $urandom());
    // A new minimum pushes the old one into second place.
    send_item(OP_APPEND, 32'd2);
    send_item(OP_APPEND, 32'd1);
    send_item(OP_REMOVE, $urandom());
    send_item(OP_READ, $urandom());
    send_item(OP_CLEAR, $urandom());

    // Random sessions, starting with one that hits the full case.
    fill_buffer();
    while (items_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 11))
        0: fill_buffer();
        1, 2: repeat (4) send_item(op_t'($urandom_range(0, 3)), $urandom());
        default: repeat ($urandom_range(8, 16)) send_item(rand_op(), rand_value());
      endcase
    end
    s_tvalid <= 1'b0;
    @(posedge clk);

    // Drain, then allow for any late stray result.
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("list_remove_second_smallest_top_tb: clean");
    end else begin
      $display("list_remove_second_smallest_top_tb: errors");
    end
    $finish;
  end

  // Result sink with random stalls and one long hold-off so the block backs up.
  initial begin
    m_tready = 1'b0;
    do begin
      @(posedge clk);
    end while (rst);
    forever begin
      reader_wait = draw_gap(results_taken);
      if (!reader_held && results_taken >= 60) begin
        reader_wait = HOLD_CYCLES;
        reader_held = 1'b1;
      end
      if (reader_wait > 0) begin
        m_tready <= 1'b0;
        repeat (reader_wait) @(posedge clk);
      end
      m_tready <= 1'b1;
      do begin
        @(posedge clk);
      end while (!m_tvalid);
      results_taken++;
    end
  end

  // Watchdog.
  initial begin
    #(10_000_000);
    $display("list_remove_second_smallest_top_tb: errors");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/lrss_pkg.sv
sv/lrss_datapath.sv
sv/lrss_ctrl.sv
sv/list_remove_second_smallest_top.sv
bench/list_remove_second_smallest_checker.sv
bench/list_remove_second_smallest_top_tb.sv
